// File: src/bma_pkg.sv
`default_nettype none

package bma_pkg;

   // payload of one input item
   typedef struct packed {
      logic [11:0] adc_sample;
      logic [31:0] time_ms;
   } req_type;

   // payload of one result item
   typedef struct packed {
      logic [14:0] filtered_mv;
      logic        battery_low;
      logic        battery_very_low;
      logic        alarm_on;
   } rsp_type;

   // shared divider widths
   localparam int DIV_NUM_W = 31;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_Q_W   = 15;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

   // register map
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERY_LOW_THRESHOLD = 1'd1;

   localparam logic [14:0] LOW_THRESHOLD_RESET      = 15'd10700;
   localparam logic [14:0] VERY_LOW_THRESHOLD_RESET = 15'd10500;

   // smoothing period in ms, 1..65535
   localparam logic [15:0] SMOOTHING_PERIOD_MS = 16'd1000;
   localparam logic [15:0] SMOOTHING_HALF_MS   = SMOOTHING_PERIOD_MS >> 1;

   localparam logic [14:0] ADC_FULL_MV      = 15'd19800;
   localparam logic [30:0] ADC_ROUND        = 31'd2048;
   localparam logic [14:0] DISCONNECT_MV    = 15'd500;
   localparam logic [14:0] EQUAL_BAND_MV    = 15'd200;
   localparam logic [14:0] ALARM_SPAN_MS    = 15'd400;
   localparam logic [9:0]  ALARM_ON_MS      = 10'd100;
   localparam logic [9:0]  ALARM_MIN_OFF_MS = 10'd100;

endpackage

`default_nettype wire

// File: src/bma_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module bma_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bma_pkg::div_req_type div_req,
   output bma_pkg::div_rsp_type      div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [3:0]                    cnt_ff, cnt_in;
   logic [bma_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [bma_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [bma_pkg::DIV_Q_W-1:0]   lo_ff, lo_in;
   logic [bma_pkg::DIV_Q_W-1:0]   quot_ff, quot_in;

   logic [bma_pkg::DIV_DEN_W:0]   trial;
   logic [bma_pkg::DIV_DEN_W:0]   diff;
   logic                          fits;

   assign trial = {rem_ff, lo_ff[bma_pkg::DIV_Q_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      lo_in   = lo_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         // quotient always fits DIV_Q_W bits, so the high part is below den
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.num[bma_pkg::DIV_NUM_W-1:bma_pkg::DIV_Q_W];
         lo_in   = div_req.num[bma_pkg::DIV_Q_W-1:0];
         den_in  = div_req.den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[bma_pkg::DIV_DEN_W-1:0] : trial[bma_pkg::DIV_DEN_W-1:0];
         lo_in   = {lo_ff[bma_pkg::DIV_Q_W-2:0], 1'b0};
         quot_in = {quot_ff[bma_pkg::DIV_Q_W-2:0], fits};
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == 4'(bma_pkg::DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      lo_ff   <= lo_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

`default_nettype wire

// File: src/battery_monitor_alarm.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  bma_pkg::req_type (adc_sample, time_ms)
// rsp       out        rsp_valid/rsp_stall  bma_pkg::rsp_type (filtered_mv, flags, alarm_on)
// csr       in         csr_we               csr_index, csr_wdata (thresholds)
//
// One item at a time. If the sample replaces the filter value and no off time is
// needed, it runs S_MV, S_FLAGS, S_ALARM; if the filter blend and off-time scaling
// both run: S_MV, S_BLEND_A/B, divider, S_FLAGS, S_SPAN, divider, S_ALARM, with one
// shared divider and a single 16x15 multiplier. Reset is synchronous; it restores
// the threshold defaults and clears control, filter and alarm state, not datapath. A
// stalled result waits in the output register; the next item is taken meanwhile.
module battery_monitor_alarm (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire bma_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output bma_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [bma_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [14:0]                     csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_MV, S_BLEND_A, S_BLEND_B, S_DIVF_GO, S_DIVF_WAIT,
      S_FLAGS, S_SPAN, S_DIVI_GO, S_DIVI_WAIT, S_ALARM
   } state_type;

   state_type         state_ff, state_in;
   logic [14:0]       low_th_ff, low_th_in;
   logic [14:0]       vlow_th_ff, vlow_th_in;
   logic [14:0]       smooth_ff, smooth_in;
   logic [31:0]       last_ff, last_in;
   logic              low_ff, low_in;
   logic              vlow_ff, vlow_in;
   logic              phase_ff, phase_in;
   logic [31:0]       toggle_ff, toggle_in;

   logic [11:0]       adc_ff, adc_in;
   logic [31:0]       now_ff, now_in;
   logic [15:0]       dt_ff, dt_in;
   logic              replace_ff, replace_in;
   logic [14:0]       mv_ff, mv_in;
   logic [30:0]       acc_ff, acc_in;
   logic [14:0]       v_ff, v_in;
   logic              nlow_ff, nlow_in;
   logic              nvlow_ff, nvlow_in;
   logic [14:0]       d_ff, d_in;
   logic [14:0]       range_ff, range_in;
   logic [9:0]        off_ff, off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bma_pkg::rsp_type  rsp_ff, rsp_in;

   logic [15:0]       mul_a;
   logic [14:0]       mul_b;
   logic [30:0]       mul_p;
   logic [30:0]       mv_sum;
   logic [31:0]       dt_full;
   logic [14:0]       range_raw;
   logic [14:0]       range_sel;
   logic [14:0]       d_raw;
   logic              flag_low;
   logic              flag_vlow;
   logic [31:0]       elapsed;
   logic [9:0]        need;
   logic              out_free;
   logic              accept;

   bma_pkg::div_req_type div_req;
   bma_pkg::div_rsp_type div_rsp;

   bma_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dt_full   = req_data.time_ms - last_ff;

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_MV: begin
            mul_a = {4'b0, adc_ff};
            mul_b = bma_pkg::ADC_FULL_MV;
         end
         S_BLEND_A: begin
            mul_a = bma_pkg::SMOOTHING_PERIOD_MS - dt_ff;
            mul_b = smooth_ff;
         end
         S_BLEND_B: begin
            mul_a = dt_ff;
            mul_b = mv_ff;
         end
         S_SPAN: begin
            mul_a = {1'b0, d_ff};
            mul_b = bma_pkg::ALARM_SPAN_MS;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = {15'b0, mul_a} * {16'b0, mul_b};
   assign mv_sum = mul_p + bma_pkg::ADC_ROUND;

   // flags with hysteresis
   always_comb begin
      flag_low  = low_ff;
      flag_vlow = vlow_ff;
      if (v_ff < bma_pkg::DISCONNECT_MV) begin
         flag_low  = 1'b0;
         flag_vlow = 1'b0;
      end else if (v_ff < vlow_th_ff) begin
         flag_low  = 1'b1;
         flag_vlow = 1'b1;
      end else if (v_ff < low_th_ff) begin
         flag_low  = 1'b1;
      end else if (v_ff == low_th_ff) begin
         flag_vlow = 1'b0;
      end else begin
         flag_low  = 1'b0;
         flag_vlow = 1'b0;
      end
   end

   assign range_raw = (low_th_ff > vlow_th_ff) ? low_th_ff - vlow_th_ff
                                                : vlow_th_ff - low_th_ff;
   assign range_sel = (range_raw == '0) ? bma_pkg::EQUAL_BAND_MV : range_raw;
   assign d_raw     = (v_ff <= vlow_th_ff) ? '0 : v_ff - vlow_th_ff;

   assign elapsed = now_ff - toggle_ff;
   assign need    = phase_ff ? bma_pkg::ALARM_ON_MS
                  : (nvlow_ff ? bma_pkg::ALARM_MIN_OFF_MS : off_ff);

   always_comb begin
      div_req.start = 1'b0;
      div_req.num   = acc_ff;
      div_req.den   = bma_pkg::SMOOTHING_PERIOD_MS;
      if (state_ff == S_DIVF_GO) begin
         div_req.start = 1'b1;
      end else if (state_ff == S_DIVI_GO) begin
         div_req.start = 1'b1;
         div_req.den   = {1'b0, range_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      low_th_in    = low_th_ff;
      vlow_th_in   = vlow_th_ff;
      smooth_in    = smooth_ff;
      last_in      = last_ff;
      low_in       = low_ff;
      vlow_in      = vlow_ff;
      phase_in     = phase_ff;
      toggle_in    = toggle_ff;
      adc_in       = adc_ff;
      now_in       = now_ff;
      dt_in        = dt_ff;
      replace_in   = replace_ff;
      mv_in        = mv_ff;
      acc_in       = acc_ff;
      v_in         = v_ff;
      nlow_in      = nlow_ff;
      nvlow_in     = nvlow_ff;
      d_in         = d_ff;
      range_in     = range_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            bma_pkg::CSR_LOW_THRESHOLD:      low_th_in  = csr_wdata;
            bma_pkg::CSR_VERY_LOW_THRESHOLD: vlow_th_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               adc_in     = req_data.adc_sample;
               now_in     = req_data.time_ms;
               dt_in      = dt_full[15:0];
               replace_in = (last_ff == '0) ||
                            (dt_full > {16'b0, bma_pkg::SMOOTHING_PERIOD_MS});
               state_in   = S_MV;
            end
         end
         S_MV: begin
            mv_in = mv_sum[26:12];
            v_in  = mv_sum[26:12];
            state_in = replace_ff ? S_FLAGS : S_BLEND_A;
         end
         S_BLEND_A: begin
            acc_in   = mul_p;
            state_in = S_BLEND_B;
         end
         S_BLEND_B: begin
            acc_in   = acc_ff + mul_p + {15'b0, bma_pkg::SMOOTHING_HALF_MS};
            state_in = S_DIVF_GO;
         end
         S_DIVF_GO: begin
            state_in = S_DIVF_WAIT;
         end
         S_DIVF_WAIT: begin
            if (div_rsp.done) begin
               v_in     = div_rsp.quot;
               state_in = S_FLAGS;
            end
         end
         S_FLAGS: begin
            nlow_in  = flag_low;
            nvlow_in = flag_vlow;
            range_in = range_sel;
            d_in     = (d_raw > range_sel) ? range_sel : d_raw;
            state_in = (flag_low && !flag_vlow && !phase_ff) ? S_SPAN : S_ALARM;
         end
         S_SPAN: begin
            acc_in   = mul_p;
            state_in = S_DIVI_GO;
         end
         S_DIVI_GO: begin
            state_in = S_DIVI_WAIT;
         end
         S_DIVI_WAIT: begin
            if (div_rsp.done) begin
               off_in   = div_rsp.quot[9:0] + bma_pkg::ALARM_MIN_OFF_MS;
               state_in = S_ALARM;
            end
         end
         S_ALARM: begin
            if (out_free) begin
               smooth_in = v_ff;
               last_in   = now_ff;
               low_in    = nlow_ff;
               vlow_in   = nvlow_ff;
               if (nlow_ff) begin
                  if (elapsed >= {22'b0, need}) begin
                     phase_in  = !phase_ff;
                     toggle_in = now_ff;
                  end
               end else begin
                  phase_in  = 1'b0;
                  toggle_in = '0;
               end
               rsp_in.filtered_mv      = v_ff;
               rsp_in.battery_low      = nlow_ff;
               rsp_in.battery_very_low = nvlow_ff;
               rsp_in.alarm_on         = phase_in;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_th_ff    <= bma_pkg::LOW_THRESHOLD_RESET;
         vlow_th_ff   <= bma_pkg::VERY_LOW_THRESHOLD_RESET;
         smooth_ff    <= '0;
         last_ff      <= '0;
         low_ff       <= 1'b0;
         vlow_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         toggle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_th_ff    <= low_th_in;
         vlow_th_ff   <= vlow_th_in;
         smooth_ff    <= smooth_in;
         last_ff      <= last_in;
         low_ff       <= low_in;
         vlow_ff      <= vlow_in;
         phase_ff     <= phase_in;
         toggle_ff    <= toggle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      adc_ff     <= adc_in;
      now_ff     <= now_in;
      dt_ff      <= dt_in;
      replace_ff <= replace_in;
      mv_ff      <= mv_in;
      acc_ff     <= acc_in;
      v_ff       <= v_in;
      nlow_ff    <= nlow_in;
      nvlow_ff   <= nvlow_in;
      d_ff       <= d_in;
      range_ff   <= range_in;
      off_ff     <= off_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
